// File: src/mbpd_pkg.sv
package mbpd_pkg;

    localparam int MAX_DIM   = 4096;
    localparam int FRAC_BITS = 14;

    localparam int CFG_W  = 13;              // config register width
    localparam int PIX_W  = 12;              // pixel coordinate width
    localparam int A_W    = 12;              // a = w-1, b = h-1
    localparam int M_W    = 13;              // |p|, |q|
    localparam int DIR_W  = 16;              // output direction fields
    localparam int ONE    = 1 << FRAC_BITS;
    localparam int G      = FRAC_BITS + 1;
    localparam int QW     = 2 * G + 1;       // quotient bits of S*2^(2G)/D
    localparam int D_W    = 4 * A_W;         // D = (ab)^2
    localparam int PB_W   = A_W + M_W;       // |p|*b, |q|*a
    localparam int S_W    = 2 * PB_W + 1;    // S
    localparam int NZ_W   = G + 1;           // Nz in Q.G
    localparam int RES_W  = QW + 1;          // square root working register
    localparam int SQ_STEPS  = G + 1;
    localparam int TQ_W   = QW - FRAC_BITS;
    localparam int PX_W   = NZ_W + M_W;      // Nz*|p|
    localparam int N2_W   = PX_W + 1;        // 2*Nz*|p| + a
    localparam int MAG_STEPS = NZ_W;
    localparam int QDEPTH = 4;
    localparam int QA_W   = $clog2(QDEPTH);
    localparam int LAT    = 3 + QW + 1 + SQ_STEPS + 1 + MAG_STEPS + 1;

    localparam logic [CFG_W-1:0] RESET_DIM = CFG_W'(512);

    typedef enum logic [1:0] {
        CFG_WIDTH  = 2'd0,
        CFG_HEIGHT = 2'd1
    } t_cfg_idx;

    // one classified pixel word between front and back
    typedef struct packed {
        logic [A_W-1:0] a;
        logic [A_W-1:0] b;
        logic [M_W-1:0] pm;
        logic [M_W-1:0] qm;
        logic           ps;
        logic           qs;
        logic           sq;
    } t_entry;

endpackage

// File: src/mirror_ball_pixel_to_direction.sv
// Channel   Direction  Handshake                  Payload
// pixel     in         push / full                i_pixel_x, i_pixel_y
// result    out        empty / pop                o_dir_x, o_dir_y, o_dir_z, o_inside_disc
// config    in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// One word per cycle unless a result waits unpopped; from queue exit a word passes
// products, a 31-stage divider, 16-stage square root, 16-stage rounding divider.
// Synchronous active-low reset clears the queue, pipeline valids and config
// (512 x 512). A stalled result freezes the whole back pipe; the 4-word
// front queue keeps taking pixels until it fills.
module mirror_ball_pixel_to_direction (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // pixel input
    input  logic                                push,
    output logic                                full,
    input  logic [mbpd_pkg::PIX_W-1:0]          i_pixel_x,
    input  logic [mbpd_pkg::PIX_W-1:0]          i_pixel_y,
    // result output
    output logic                                empty,
    input  logic                                pop,
    output logic signed [mbpd_pkg::DIR_W-1:0]   o_dir_x,
    output logic signed [mbpd_pkg::DIR_W-1:0]   o_dir_y,
    output logic signed [mbpd_pkg::DIR_W-1:0]   o_dir_z,
    output logic                                o_inside_disc,
    // config write
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [1:0]                          i_cfg_index,
    input  logic [mbpd_pkg::CFG_W-1:0]          i_cfg_data
);

    logic [mbpd_pkg::CFG_W-1:0] r_width, r_height;
    mbpd_pkg::t_entry front_word, q_word;
    logic q_empty, q_pop;

    // config always accepted; an unknown index is dropped
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= mbpd_pkg::RESET_DIM;
            r_height <= mbpd_pkg::RESET_DIM;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == mbpd_pkg::CFG_WIDTH) begin
                r_width <= i_cfg_data;
            end
            if (i_cfg_index == mbpd_pkg::CFG_HEIGHT) begin
                r_height <= i_cfg_data;
            end
        end
    end

    // front: clamp dimensions, center and fold the pixel, square test
    mbpd_front u_front (
        .i_width   (r_width),
        .i_height  (r_height),
        .i_pixel_x (i_pixel_x),
        .i_pixel_y (i_pixel_y),
        .o_entry   (front_word)
    );

    mbpd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_word),
        .o_full  (full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_data  (q_word)
    );

    // back: disc test, Nz, reflection, rounding
    mbpd_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_empty     (q_empty),
        .i_q_data      (q_word),
        .o_q_pop       (q_pop),
        .i_pop         (pop),
        .o_empty       (empty),
        .o_dir_x       (o_dir_x),
        .o_dir_y       (o_dir_y),
        .o_dir_z       (o_dir_z),
        .o_inside_disc (o_inside_disc)
    );

endmodule

// File: src/mbpd_front.sv
module mbpd_front (
    input  logic [mbpd_pkg::CFG_W-1:0] i_width,
    input  logic [mbpd_pkg::CFG_W-1:0] i_height,
    input  logic [mbpd_pkg::PIX_W-1:0] i_pixel_x,
    input  logic [mbpd_pkg::PIX_W-1:0] i_pixel_y,
    output mbpd_pkg::t_entry           o_entry
);

    function automatic logic [mbpd_pkg::CFG_W-1:0] eff_dim(
        input logic [mbpd_pkg::CFG_W-1:0] d
    );
        if (d < mbpd_pkg::CFG_W'(2))
            return mbpd_pkg::CFG_W'(2);
        else if (d > mbpd_pkg::CFG_W'(mbpd_pkg::MAX_DIM))
            return mbpd_pkg::CFG_W'(mbpd_pkg::MAX_DIM);
        else
            return d;
    endfunction

    logic [mbpd_pkg::CFG_W-1:0] weff, heff, wm1, hm1;
    logic [mbpd_pkg::A_W-1:0]   a, b;
    logic signed [mbpd_pkg::A_W+1:0] p, q;

    always_comb begin
        weff = eff_dim(i_width);
        heff = eff_dim(i_height);
        wm1  = weff - mbpd_pkg::CFG_W'(1);
        hm1  = heff - mbpd_pkg::CFG_W'(1);
        a    = wm1[mbpd_pkg::A_W-1:0];
        b    = hm1[mbpd_pkg::A_W-1:0];
        // p = a - 2x, q = 2y - b
        p    = $signed({2'b00, a}) - $signed({1'b0, i_pixel_x, 1'b0});
        q    = $signed({1'b0, i_pixel_y, 1'b0}) - $signed({2'b00, b});
        o_entry.a  = a;
        o_entry.b  = b;
        o_entry.ps = p[mbpd_pkg::A_W+1];
        o_entry.qs = q[mbpd_pkg::A_W+1];
        o_entry.pm = p[mbpd_pkg::A_W+1] ? mbpd_pkg::M_W'(-p) : mbpd_pkg::M_W'(p);
        o_entry.qm = q[mbpd_pkg::A_W+1] ? mbpd_pkg::M_W'(-q) : mbpd_pkg::M_W'(q);
        o_entry.sq = (weff == heff);
    end

endmodule

// File: src/mbpd_queue.sv
module mbpd_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  mbpd_pkg::t_entry i_data,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_empty,
    output mbpd_pkg::t_entry o_data
);

    mbpd_pkg::t_entry r_mem [mbpd_pkg::QDEPTH];
    logic [mbpd_pkg::QA_W-1:0] r_wp, r_rp;
    logic [mbpd_pkg::QA_W:0]   r_cnt;
    logic do_push, do_pop;

    assign o_full  = (r_cnt == (mbpd_pkg::QA_W+1)'(mbpd_pkg::QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + mbpd_pkg::QA_W'(1);
            end
            if (do_pop) begin
                r_rp <= r_rp + mbpd_pkg::QA_W'(1);
            end
            r_cnt <= r_cnt + (mbpd_pkg::QA_W+1)'(do_push) - (mbpd_pkg::QA_W+1)'(do_pop);
        end
    end

endmodule

// File: src/mbpd_back.sv
module mbpd_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_q_empty,
    input  mbpd_pkg::t_entry            i_q_data,
    output logic                        o_q_pop,
    input  logic                        i_pop,
    output logic                        o_empty,
    output logic signed [mbpd_pkg::DIR_W-1:0] o_dir_x,
    output logic signed [mbpd_pkg::DIR_W-1:0] o_dir_y,
    output logic signed [mbpd_pkg::DIR_W-1:0] o_dir_z,
    output logic                        o_inside_disc
);

    localparam int LAT = mbpd_pkg::LAT;
    localparam int QW  = mbpd_pkg::QW;
    localparam int D_W = mbpd_pkg::D_W;
    localparam int SQN = mbpd_pkg::SQ_STEPS;
    localparam int MGN = mbpd_pkg::MAG_STEPS;
    localparam int N2W = mbpd_pkg::N2_W;
    localparam int DW  = mbpd_pkg::DIR_W;

    function automatic logic [DW-1:0] comp(input logic [MGN-1:0] mag, input logic neg);
        logic [DW-1:0] m;
        m = (mag > MGN'(mbpd_pkg::ONE)) ? DW'(mbpd_pkg::ONE) : DW'(mag);
        return neg ? (DW'(0) - m) : m;
    endfunction

    logic en;
    logic [LAT-1:0] r_vld;

    // whole pipe moves when the output word is free or being taken
    assign en      = !r_vld[LAT-1] || i_pop;
    assign o_q_pop = en && !i_q_empty;
    assign o_empty = !r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], !i_q_empty};
        end
    end

    // products
    logic [mbpd_pkg::PB_W-1:0] r1_pb, r1_qa;
    logic [2*mbpd_pkg::A_W-1:0] r1_ab;
    mbpd_pkg::t_entry r1_c;
    logic [2*mbpd_pkg::PB_W-1:0] r2_pb2, r2_qa2;
    logic [D_W-1:0] r2_d;
    mbpd_pkg::t_entry r2_c;
    logic [D_W-1:0] r3_num, r3_d;
    mbpd_pkg::t_entry r3_c;
    logic r3_o;
    logic [mbpd_pkg::S_W-1:0] s_sum;
    logic s_out;

    assign s_sum = mbpd_pkg::S_W'(r2_pb2) + mbpd_pkg::S_W'(r2_qa2);
    assign s_out = s_sum > mbpd_pkg::S_W'(r2_d);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_pb  <= mbpd_pkg::PB_W'(i_q_data.pm) * mbpd_pkg::PB_W'(i_q_data.b);
            r1_qa  <= mbpd_pkg::PB_W'(i_q_data.qm) * mbpd_pkg::PB_W'(i_q_data.a);
            r1_ab  <= (2*mbpd_pkg::A_W)'(i_q_data.a) * (2*mbpd_pkg::A_W)'(i_q_data.b);
            r1_c   <= i_q_data;
            r2_pb2 <= (2*mbpd_pkg::PB_W)'(r1_pb) * (2*mbpd_pkg::PB_W)'(r1_pb);
            r2_qa2 <= (2*mbpd_pkg::PB_W)'(r1_qa) * (2*mbpd_pkg::PB_W)'(r1_qa);
            r2_d   <= D_W'(r1_ab) * D_W'(r1_ab);
            r2_c   <= r1_c;
            // outside: divide D by D, result is overridden at the end
            r3_num <= s_out ? r2_d : s_sum[D_W-1:0];
            r3_d   <= r2_d;
            r3_c   <= r2_c;
            r3_o   <= s_out;
        end
    end

    // restoring divider, one quotient bit per stage: Q = floor(S*2^(2G)/D)
    logic [D_W-1:0]   r_dr [QW];
    logic [QW-1:0]    r_dq [QW];
    logic [D_W-1:0]   r_dd [QW];
    mbpd_pkg::t_entry r_dc [QW];
    logic             r_do [QW];

    genvar gi;
    generate
        for (gi = 0; gi < QW; gi++) begin : g_div
            logic [D_W:0]     sh;
            logic [D_W-1:0]   dd;
            logic [QW-1:0]    qp;
            mbpd_pkg::t_entry cc;
            logic             oo;
            logic             ge;
            logic [D_W:0]     df;
            if (gi == 0) begin : g_first
                assign sh = {1'b0, r3_num};
                assign dd = r3_d;
                assign qp = '0;
                assign cc = r3_c;
                assign oo = r3_o;
            end else begin : g_next
                assign sh = {r_dr[gi-1], 1'b0};
                assign dd = r_dd[gi-1];
                assign qp = r_dq[gi-1];
                assign cc = r_dc[gi-1];
                assign oo = r_do[gi-1];
            end
            assign ge = sh >= {1'b0, dd};
            assign df = sh - {1'b0, dd};
            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_dr[gi] <= ge ? df[D_W-1:0] : sh[D_W-1:0];
                    r_dq[gi] <= {qp[QW-2:0], ge};
                    r_dd[gi] <= dd;
                    r_dc[gi] <= cc;
                    r_do[gi] <= oo;
                end
            end
        end
    endgenerate

    // Nz^2 = 2^(2G) - ceil(S*2^(2G)/D); dir_z from the top quotient bits
    logic [QW-1:0] rp_nz2;
    logic [DW-1:0] rp_dz;
    mbpd_pkg::t_entry rp_c;
    logic rp_o;
    logic [QW-1:0] pq;
    logic [mbpd_pkg::TQ_W:0] t_inc;
    logic [DW+1:0] z_full;

    assign pq     = r_dq[QW-1];
    assign t_inc  = ((mbpd_pkg::TQ_W+1)'(pq[QW-1:mbpd_pkg::FRAC_BITS]) +
                     (mbpd_pkg::TQ_W+1)'(1)) >> 1;
    assign z_full = (DW+2)'(mbpd_pkg::ONE) - (DW+2)'(t_inc);

    always_ff @(posedge i_clk) begin
        if (en) begin
            rp_nz2 <= (QW'(1) << (2*mbpd_pkg::G)) - pq - QW'(r_dr[QW-1] != '0);
            rp_dz  <= z_full[DW-1:0];
            rp_c   <= r_dc[QW-1];
            rp_o   <= r_do[QW-1];
        end
    end

    // integer square root, one result bit per stage
    logic [QW-1:0]          r_sr [SQN];
    logic [mbpd_pkg::RES_W-1:0] r_ss [SQN];
    mbpd_pkg::t_entry       r_sc [SQN];
    logic                   r_so [SQN];
    logic [DW-1:0]          r_sz [SQN];

    generate
        for (gi = 0; gi < SQN; gi++) begin : g_sqrt
            localparam logic [mbpd_pkg::RES_W-1:0] BITK =
                mbpd_pkg::RES_W'(1) << (2*mbpd_pkg::G - 2*gi);
            logic [QW-1:0]              rem;
            logic [mbpd_pkg::RES_W-1:0] res, tryv;
            mbpd_pkg::t_entry           cc;
            logic                       oo;
            logic [DW-1:0]              zz;
            logic                       ge;
            if (gi == 0) begin : g_first
                assign rem = rp_nz2;
                assign res = '0;
                assign cc  = rp_c;
                assign oo  = rp_o;
                assign zz  = rp_dz;
            end else begin : g_next
                assign rem = r_sr[gi-1];
                assign res = r_ss[gi-1];
                assign cc  = r_sc[gi-1];
                assign oo  = r_so[gi-1];
                assign zz  = r_sz[gi-1];
            end
            assign tryv = res + BITK;
            assign ge   = {1'b0, rem} >= tryv;
            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_sr[gi] <= ge ? (rem - tryv[QW-1:0]) : rem;
                    r_ss[gi] <= ge ? ((res >> 1) + BITK) : (res >> 1);
                    r_sc[gi] <= cc;
                    r_so[gi] <= oo;
                    r_sz[gi] <= zz;
                end
            end
        end
    endgenerate

    // Nz * |p|, Nz * |q|
    logic [mbpd_pkg::PX_W-1:0] rm_px, rm_py;
    logic [mbpd_pkg::NZ_W-1:0] nz;
    mbpd_pkg::t_entry rm_c;
    logic rm_o;
    logic [DW-1:0] rm_dz;

    assign nz = r_ss[SQN-1][mbpd_pkg::NZ_W-1:0];

    always_ff @(posedge i_clk) begin
        if (en) begin
            rm_px <= mbpd_pkg::PX_W'(nz) * mbpd_pkg::PX_W'(r_sc[SQN-1].pm);
            rm_py <= mbpd_pkg::PX_W'(nz) * mbpd_pkg::PX_W'(r_sc[SQN-1].qm);
            rm_c  <= r_sc[SQN-1];
            rm_o  <= r_so[SQN-1];
            rm_dz <= r_sz[SQN-1];
        end
    end

    // rounded quotients (2*prod+a)/(2a) for x, b for y, one bit per stage, side by side
    logic [N2W-1:0]   r_xr [MGN];
    logic [N2W-1:0]   r_yr [MGN];
    logic [MGN-1:0]   r_xq [MGN];
    logic [MGN-1:0]   r_yq [MGN];
    mbpd_pkg::t_entry r_mc [MGN];
    logic             r_mo [MGN];
    logic [DW-1:0]    r_mz [MGN];

    generate
        for (gi = 0; gi < MGN; gi++) begin : g_mag
            localparam int BP = MGN - 1 - gi;
            logic [N2W-1:0]   xr, yr, xd, yd;
            logic [MGN-1:0]   xq, yq;
            mbpd_pkg::t_entry cc;
            logic             oo;
            logic [DW-1:0]    zz;
            logic             xge, yge;
            if (gi == 0) begin : g_first
                assign xr = {rm_px, 1'b0} + N2W'(rm_c.a);
                assign yr = {rm_py, 1'b0} + N2W'(rm_c.b);
                assign xq = '0;
                assign yq = '0;
                assign cc = rm_c;
                assign oo = rm_o;
                assign zz = rm_dz;
            end else begin : g_next
                assign xr = r_xr[gi-1];
                assign yr = r_yr[gi-1];
                assign xq = r_xq[gi-1];
                assign yq = r_yq[gi-1];
                assign cc = r_mc[gi-1];
                assign oo = r_mo[gi-1];
                assign zz = r_mz[gi-1];
            end
            assign xd  = N2W'({cc.a, 1'b0}) << BP;
            assign yd  = N2W'({cc.b, 1'b0}) << BP;
            assign xge = xr >= xd;
            assign yge = yr >= yd;
            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_xr[gi] <= xge ? (xr - xd) : xr;
                    r_yr[gi] <= yge ? (yr - yd) : yr;
                    r_xq[gi] <= {xq[MGN-2:0], xge};
                    r_yq[gi] <= {yq[MGN-2:0], yge};
                    r_mc[gi] <= cc;
                    r_mo[gi] <= oo;
                    r_mz[gi] <= zz;
                end
            end
        end
    endgenerate

    // saturate, sign, and apply the outside-disc result
    logic [DW-1:0] r_fx, r_fy, r_fz;
    logic r_fin;

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (r_mo[MGN-1]) begin
                r_fx  <= '0;
                r_fy  <= '0;
                r_fz  <= DW'(0) - DW'(mbpd_pkg::ONE);
                r_fin <= 1'b0;
            end else begin
                r_fx  <= comp(r_xq[MGN-1], r_mc[MGN-1].ps);
                r_fy  <= comp(r_yq[MGN-1], r_mc[MGN-1].qs);
                r_fz  <= r_mz[MGN-1];
                r_fin <= r_mc[MGN-1].sq;
            end
        end
    end

    assign o_dir_x       = $signed(r_fx);
    assign o_dir_y       = $signed(r_fy);
    assign o_dir_z       = $signed(r_fz);
    assign o_inside_disc = r_fin;

endmodule
